// ----- hw/rtl/rgbled_pkg.sv -----
// Package: shared types, constants and helpers for the RGB LED SPI bit encoder.
package rgbled_pkg;

    // Frame buffer size in bytes and the LED capacity it gives per mode
    localparam int BUFFER_BYTES       = 3840;
    localparam int BYTES_PER_LED_RGBW = 16;
    localparam int BYTES_PER_LED_RGB  = 12;
    localparam int CAP_RGBW           = BUFFER_BYTES / BYTES_PER_LED_RGBW;
    localparam int CAP_RGB            = BUFFER_BYTES / BYTES_PER_LED_RGB;
    localparam int CAP_MAX            = (CAP_RGB > CAP_RGBW) ? CAP_RGB : CAP_RGBW;
    localparam int CNT_W              = $clog2(CAP_MAX + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_RGBW_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_HALFWORDS = 2'd1;

    // Colour slot order on the wire: green, red, blue, white
    localparam logic [1:0] SLOT_GREEN = 2'd0;
    localparam logic [1:0] SLOT_RED   = 2'd1;
    localparam logic [1:0] SLOT_BLUE  = 2'd2;
    localparam logic [1:0] SLOT_WHITE = 2'd3;

    // Input beat: one LED
    typedef struct packed {
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
        logic [7:0] white_level;
        logic [7:0] brightness;
        logic       frame_end;
    } led_item_t;

    // Output beat: one SPI word
    typedef struct packed {
        logic [31:0] encoded_word;
        logic        word_valid;
        logic        last_word;
        logic        frame_done;
        logic        dropped;
    } spi_word_t;

    // Two data bits to two 4-bit symbols (0 -> 1000, 1 -> 1110)
    function automatic logic [7:0] symbol_pair(input logic [1:0] bits);
        logic [7:0] sym;
        case (bits)
            2'b00:   sym = 8'b1000_1000;
            2'b01:   sym = 8'b1000_1110;
            2'b10:   sym = 8'b1110_1000;
            2'b11:   sym = 8'b1110_1110;
            default: sym = 8'b1000_1000;
        endcase
        return sym;
    endfunction

endpackage

// ----- hw/rtl/rgbled_word_enc.sv -----
// Scales one colour level by brightness and encodes it as a 32-bit SPI word.
module rgbled_word_enc (
    input  logic [7:0]  level,
    input  logic [7:0]  brightness,
    input  logic        swap_halfwords,
    output logic [31:0] encoded_word
);
    import rgbled_pkg::*;

    logic [15:0] product;
    logic [7:0]  scaled;
    logic [7:0]  s3, s2, s1, s0;

    // Rounded-up scaling; the sum never exceeds 16 bits
    assign product = ({8'd0, level} * {8'd0, brightness}) + 16'd255;
    assign scaled  = product[15:8];

    // Bit pairs to symbol pairs, MSB first
    assign s3 = symbol_pair(scaled[7:6]);
    assign s2 = symbol_pair(scaled[5:4]);
    assign s1 = symbol_pair(scaled[3:2]);
    assign s0 = symbol_pair(scaled[1:0]);

    // Optional byte reorder for 16-bit transfers
    assign encoded_word = swap_halfwords ? {s2, s3, s0, s1} : {s3, s2, s1, s0};

endmodule

// ----- hw/rtl/rgb_led_spi_bit_encoder.sv -----
// Top level: RGB(W) LED to SPI bit-pattern encoder.
// An accepted LED is first held in the LED register; its words then pass through the output register.
// Throughput: one word per cycle while result_ready holds; an LED gives 3 words (RGB), 4 (RGBW) or 1 if dropped.
// A new LED is taken in the cycle its last word moves into the output register.
// Reset: asynchronous, active low; clears mode, swap, frame counter and all valids.
module rgb_led_spi_bit_encoder (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  rgbled_pkg::led_item_t            item,
    output logic                             result_valid,
    input  logic                             result_ready,
    output rgbled_pkg::spi_word_t            result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rgbled_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                             cfg_data
);
    import rgbled_pkg::*;

    localparam logic [CNT_W-1:0] CAP_RGBW_C = CNT_W'(CAP_RGBW);
    localparam logic [CNT_W-1:0] CAP_RGB_C  = CNT_W'(CAP_RGB);

    // Configuration and frame counter
    logic             rgbw_mode_reg;
    logic             swap_reg;
    logic [CNT_W-1:0] leds_reg, leds_next;

    // Held LED and word sequencer
    led_item_t  led_reg;
    logic       busy_reg;
    logic       drop_reg;
    logic       four_reg;
    logic [1:0] slot_reg;

    // Output register
    logic      out_valid_reg;
    spi_word_t out_reg;

    logic       accept;
    logic       out_load;
    logic       last_slot;
    logic       drop_now;
    logic [7:0] level_sel;
    logic [31:0] word_enc;
    spi_word_t  word_next;

    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Handshake
    assign out_load   = busy_reg && (!out_valid_reg || result_ready);
    assign last_slot  = drop_reg || (slot_reg == (four_reg ? SLOT_WHITE : SLOT_BLUE));
    assign item_ready = !busy_reg || (out_load && last_slot);
    assign accept     = item_valid && item_ready;

    // Capacity check against the mode in force now
    assign drop_now = leds_reg >= (rgbw_mode_reg ? CAP_RGBW_C : CAP_RGB_C);

    always_comb
    begin
        leds_next = leds_reg;
        if (item.frame_end)
        begin
            leds_next = '0;
        end
        else if (!drop_now)
        begin
            leds_next = leds_reg + CNT_W'(1);
        end
    end

    // Colour for the current slot
    always_comb
    begin
        case (slot_reg)
            SLOT_GREEN: level_sel = led_reg.green_level;
            SLOT_RED:   level_sel = led_reg.red_level;
            SLOT_BLUE:  level_sel = led_reg.blue_level;
            SLOT_WHITE: level_sel = led_reg.white_level;
            default:    level_sel = led_reg.green_level;
        endcase
    end

    rgbled_word_enc u_word_enc (
        .level          (level_sel),
        .brightness     (led_reg.brightness),
        .swap_halfwords (swap_reg),
        .encoded_word   (word_enc)
    );

    // Result beat for this slot
    always_comb
    begin
        word_next.encoded_word = drop_reg ? 32'd0 : word_enc;
        word_next.word_valid   = !drop_reg;
        word_next.last_word    = last_slot;
        word_next.frame_done   = last_slot && led_reg.frame_end;
        word_next.dropped      = drop_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rgbw_mode_reg <= 1'b0;
            swap_reg      <= 1'b0;
            leds_reg      <= '0;
            busy_reg      <= 1'b0;
            slot_reg      <= SLOT_GREEN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == REG_RGBW_MODE)
                begin
                    rgbw_mode_reg <= cfg_data;
                end
                else if (cfg_index == REG_SWAP_HALFWORDS)
                begin
                    swap_reg <= cfg_data;
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (accept)
            begin
                busy_reg <= 1'b1;
                slot_reg <= SLOT_GREEN;
                leds_reg <= leds_next;
            end
            else if (out_load)
            begin
                if (last_slot)
                begin
                    busy_reg <= 1'b0;
                end
                slot_reg <= slot_reg + 2'd1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            led_reg  <= item;
            drop_reg <= drop_now;
            four_reg <= rgbw_mode_reg;
        end
        if (out_load)
        begin
            out_reg <= word_next;
        end
    end

endmodule
